/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the one-time password generator, used by the counter queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk once reset is released.
`define TOTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every rising edge of aclk, also while reset is asserted.
`define TOTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/totp_pkg.sv */
// Shared types, constants and SHA-1 helper functions for the one-time password generator.
package totp_pkg;

    localparam int KEY_BYTES  = 16;
    localparam int TS_W       = 63;
    localparam int STEP_W     = 16;
    localparam int MOD_W      = 30;
    localparam int CODE_W     = 30;
    localparam int TRUNC_W    = 31;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    localparam logic [1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [1:0] REG_KEY_LOWER = 2'd1;
    localparam logic [1:0] REG_TIME_STEP = 2'd2;
    localparam logic [1:0] REG_CODE_MOD  = 2'd3;

    localparam logic [1:0] BLK_IPAD = 2'd0;
    localparam logic [1:0] BLK_MSG  = 2'd1;
    localparam logic [1:0] BLK_OPAD = 2'd2;
    localparam logic [1:0] BLK_DIG  = 2'd3;

    typedef logic [31:0]  word_t;
    typedef logic [159:0] digest_t;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } key_t;

    localparam digest_t SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam word_t IPAD_WORD   = 32'h36363636;
    localparam word_t OPAD_WORD   = 32'h5C5C5C5C;
    localparam word_t PAD_WORD    = 32'h80000000;
    localparam word_t INNER_BITS  = 32'd576;
    localparam word_t OUTER_BITS  = 32'd672;

    function automatic word_t key_word(key_t key, logic [1:0] idx);
        logic [127:0] kv;
        logic [127:0] km;
        kv = {key.upper, key.lower};
        km = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < KEY_BYTES) begin
                km[127 - 8 * i -: 8] = kv[127 - 8 * i -: 8];
            end
        end
        return km[127 - 32 * idx -: 32];
    endfunction

    function automatic word_t block_word(logic [1:0] blk, logic [3:0] idx, key_t key,
                                         logic [TS_W-1:0] ctr, digest_t dig);
        word_t w;
        w = '0;
        case (blk)
            BLK_IPAD: w = (idx < 4'd4) ? (key_word(key, idx[1:0]) ^ IPAD_WORD) : IPAD_WORD;
            BLK_OPAD: w = (idx < 4'd4) ? (key_word(key, idx[1:0]) ^ OPAD_WORD) : OPAD_WORD;
            BLK_MSG: begin
                case (idx)
                    4'd0:    w = {1'b0, ctr[TS_W-1:32]};
                    4'd1:    w = ctr[31:0];
                    4'd2:    w = PAD_WORD;
                    4'd15:   w = INNER_BITS;
                    default: w = '0;
                endcase
            end
            default: begin
                if (idx < 4'd5) begin
                    w = dig[159 - 32 * idx -: 32];
                end else if (idx == 4'd5) begin
                    w = PAD_WORD;
                end else if (idx == 4'd15) begin
                    w = OUTER_BITS;
                end else begin
                    w = '0;
                end
            end
        endcase
        return w;
    endfunction

    function automatic digest_t sha1_round(digest_t s, word_t w, logic [6:0] t);
        word_t a, b, c, d, e, f, k, tmp;
        a = s[159:128];
        b = s[127:96];
        c = s[95:64];
        d = s[63:32];
        e = s[31:0];
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
        end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + w;
        return {tmp, a, {b[1:0], b[31:2]}, c, d};
    endfunction

endpackage

/* hw/rtl/totp_code_generator_top.sv */
// Top level of the one-time password generator: register port, front end, queue, back end.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_timestamp[62:0]
//   m_       out        m_valid/m_ready    m_code[29:0]
//   APB      in/out     psel/penable       paddr[4:0], pwdata/prdata[63:0]
//
// The front end divides a timestamp by the time step, one quotient bit per cycle.
// The back end takes one item at a time: four SHA-1 blocks on one shared round unit, then,
// unless the modulus is zero, remainder steps and the output register.
// A two-entry queue lets the divider run ahead while the back end is busy.
// Reset is synchronous on aresetn low and returns the control and configuration registers to their defaults.
// A stalled m_ready holds the result; the back end finishes its next item and waits.
module totp_code_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [totp_pkg::TS_W-1:0]       s_timestamp,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [totp_pkg::CODE_W-1:0]     m_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [4:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    logic [63:0]                    key_upper_reg;
    logic [63:0]                    key_lower_reg;
    logic [totp_pkg::STEP_W-1:0]    time_step_reg;
    logic [totp_pkg::MOD_W-1:0]     code_modulus_reg;
    logic [1:0]                     reg_idx;
    logic                           wr_en;
    totp_pkg::key_t                 key;
    logic                           f_valid, f_ready;
    logic [totp_pkg::TS_W-1:0]      f_counter;
    logic                           q_valid, q_ready;
    logic [totp_pkg::TS_W-1:0]      q_counter;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:3];
    assign wr_en     = psel && penable && pwrite && pready;
    assign key.upper = key_upper_reg;
    assign key.lower = key_lower_reg;

    always_comb begin
        case (reg_idx)
            totp_pkg::REG_KEY_UPPER: prdata = key_upper_reg;
            totp_pkg::REG_KEY_LOWER: prdata = key_lower_reg;
            totp_pkg::REG_TIME_STEP: prdata = 64'(time_step_reg);
            totp_pkg::REG_CODE_MOD:  prdata = 64'(code_modulus_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg    <= '0;
            key_lower_reg    <= '0;
            time_step_reg    <= totp_pkg::STEP_W'(30);
            code_modulus_reg <= totp_pkg::MOD_W'(1000000);
        end else if (wr_en) begin
            case (reg_idx)
                totp_pkg::REG_KEY_UPPER: key_upper_reg    <= pwdata;
                totp_pkg::REG_KEY_LOWER: key_lower_reg    <= pwdata;
                totp_pkg::REG_TIME_STEP: time_step_reg    <= pwdata[totp_pkg::STEP_W-1:0];
                totp_pkg::REG_CODE_MOD:  code_modulus_reg <= pwdata[totp_pkg::MOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    totp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_timestamp (s_timestamp),
        .time_step   (time_step_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_counter (f_counter)
    );

    totp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_counter),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_counter)
    );

    totp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_counter   (q_counter),
        .key          (key),
        .code_modulus (code_modulus_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code       (m_code)
    );

endmodule

/* hw/rtl/totp_front.sv */
// Front end: accepts timestamps and divides them by the time step into counters; a zero time step divides by one.
module totp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [totp_pkg::TS_W-1:0]     s_timestamp,
    input  logic [totp_pkg::STEP_W-1:0]   time_step,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [totp_pkg::TS_W-1:0]     out_counter
);

    localparam int CNT_W = $clog2(totp_pkg::TS_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(totp_pkg::TS_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [totp_pkg::TS_W-1:0]     num_reg, num_next;
    logic [totp_pkg::STEP_W-1:0]   rem_reg, rem_next;
    logic [totp_pkg::STEP_W-1:0]   div_reg, div_next;
    logic [totp_pkg::STEP_W:0]     trial;

    assign s_ready     = !busy_reg;
    assign out_valid   = done_reg;
    assign out_counter = num_reg;
    assign trial       = {rem_reg, num_reg[totp_pkg::TS_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                done_next = 1'b0;
                cnt_next  = '0;
                num_next  = s_timestamp;
                rem_next  = '0;
                div_next  = (time_step == '0) ? totp_pkg::STEP_W'(1) : time_step;
            end
        end else if (!done_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = totp_pkg::STEP_W'(trial - {1'b0, div_reg});
                num_next = {num_reg[totp_pkg::TS_W-2:0], 1'b1};
            end else begin
                rem_next = trial[totp_pkg::STEP_W-1:0];
                num_next = {num_reg[totp_pkg::TS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT) begin
                done_next = 1'b1;
            end
        end else if (out_ready) begin
            busy_next = 1'b0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

/* hw/rtl/totp_fifo.sv */
// Short counter queue between the divider front end and the HMAC back end.
`include "assert_macros.svh"

module totp_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [totp_pkg::TS_W-1:0]     in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [totp_pkg::TS_W-1:0]     out_data
);

    logic [totp_pkg::TS_W-1:0]     mem_reg [totp_pkg::FIFO_DEPTH];
    logic [totp_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [totp_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [totp_pkg::FIFO_CW-1:0]  count_reg, count_next;
    logic                          push, pop;

    assign in_ready  = (count_reg != totp_pkg::FIFO_CW'(totp_pkg::FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `TOTP_ASSERT(a_count_bound, (count_reg <= totp_pkg::FIFO_CW'(totp_pkg::FIFO_DEPTH)), "queue count exceeds depth")
    `TOTP_ASSERT(a_ptr_gap, (count_reg == '0 || count_reg == totp_pkg::FIFO_CW'(totp_pkg::FIFO_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")
    `TOTP_ASSERT(a_pop_last, (count_reg == totp_pkg::FIFO_CW'(1) && pop && !push) |=> !out_valid, "queue not empty after last pop")
    `TOTP_ASSERT_ALWAYS(a_reset_empty, (!aresetn) |=> (count_reg == '0), "queue not empty after reset")

endmodule

/* hw/rtl/totp_back.sv */
// Back end: HMAC-SHA1 over the counter, dynamic truncation and modulus reduction (skipped for a zero modulus).
module totp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [totp_pkg::TS_W-1:0]     in_counter,
    input  totp_pkg::key_t                key,
    input  logic [totp_pkg::MOD_W-1:0]    code_modulus,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [totp_pkg::CODE_W-1:0]   m_code
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int MCNT_W = $clog2(totp_pkg::TRUNC_W);
    localparam logic [MCNT_W-1:0] MOD_LAST = MCNT_W'(totp_pkg::TRUNC_W - 1);
    localparam logic [6:0] ROUND_LAST = 7'd79;

    logic [2:0]                      state_reg, state_next;
    logic [totp_pkg::TS_W-1:0]       ctr_reg, ctr_next;
    logic [1:0]                      blk_reg, blk_next;
    logic [6:0]                      rnd_reg, rnd_next;
    totp_pkg::digest_t               h_reg, h_next;
    totp_pkg::digest_t               v_reg, v_next;
    totp_pkg::digest_t               inner_reg, inner_next;
    totp_pkg::word_t                 win_reg [16];
    totp_pkg::word_t                 win_next [16];
    logic [totp_pkg::TRUNC_W-1:0]    trunc_reg, trunc_next;
    logic [totp_pkg::MOD_W-1:0]      rem_reg, rem_next;
    logic [MCNT_W-1:0]               mcnt_reg, mcnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [totp_pkg::CODE_W-1:0]     m_code_reg, m_code_next;
    totp_pkg::digest_t               hsum;
    logic [3:0]                      offset;
    logic [31:0]                     picked;
    logic [totp_pkg::MOD_W:0]        trial;

    assign in_ready = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_code   = m_code_reg;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            hsum[159 - 32 * i -: 32] = h_reg[159 - 32 * i -: 32] + v_reg[159 - 32 * i -: 32];
        end
        offset = hsum[3:0];
        picked = hsum[159 - 8 * offset -: 32];
        trial  = {rem_reg, trunc_reg[totp_pkg::TRUNC_W-1]};
    end

    always_comb begin
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        blk_next     = blk_reg;
        rnd_next     = rnd_reg;
        h_next       = h_reg;
        v_next       = v_reg;
        inner_next   = inner_reg;
        win_next     = win_reg;
        trunc_next   = trunc_reg;
        rem_next     = rem_reg;
        mcnt_next    = mcnt_reg;
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ctr_next   = in_counter;
                    blk_next   = totp_pkg::BLK_IPAD;
                    h_next     = totp_pkg::SHA1_IV;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                for (int i = 0; i < 16; i++) begin
                    win_next[i] = totp_pkg::block_word(blk_reg, 4'(i), key, ctr_reg, inner_reg);
                end
                v_next     = h_reg;
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                v_next = totp_pkg::sha1_round(v_reg, win_reg[0], rnd_reg);
                for (int i = 0; i < 15; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = {win_reg[13][30:0] ^ win_reg[8][30:0] ^ win_reg[2][30:0]
                                ^ win_reg[0][30:0],
                                win_reg[13][31] ^ win_reg[8][31] ^ win_reg[2][31]
                                ^ win_reg[0][31]};
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (blk_reg == totp_pkg::BLK_MSG) begin
                    inner_next = hsum;
                    h_next     = totp_pkg::SHA1_IV;
                    blk_next   = totp_pkg::BLK_OPAD;
                    state_next = ST_LOAD;
                end else if (blk_reg == totp_pkg::BLK_DIG) begin
                    trunc_next = picked[totp_pkg::TRUNC_W-1:0];
                    rem_next   = '0;
                    mcnt_next  = '0;
                    if (code_modulus == '0) begin
                        rem_next   = picked[totp_pkg::CODE_W-1:0];
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_MOD;
                    end
                end else begin
                    h_next     = hsum;
                    blk_next   = blk_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_MOD: begin
                if (trial >= {1'b0, code_modulus}) begin
                    rem_next = totp_pkg::MOD_W'(trial - {1'b0, code_modulus});
                end else begin
                    rem_next = trial[totp_pkg::MOD_W-1:0];
                end
                trunc_next = {trunc_reg[totp_pkg::TRUNC_W-2:0], 1'b0};
                mcnt_next  = mcnt_reg + 1'b1;
                if (mcnt_reg == MOD_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_code_next  = rem_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            blk_reg     <= '0;
            rnd_reg     <= '0;
            mcnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            blk_reg     <= blk_next;
            rnd_reg     <= rnd_next;
            mcnt_reg    <= mcnt_next;
        end
        ctr_reg    <= ctr_next;
        h_reg      <= h_next;
        v_reg      <= v_next;
        inner_reg  <= inner_next;
        win_reg    <= win_next;
        trunc_reg  <= trunc_next;
        rem_reg    <= rem_next;
        m_code_reg <= m_code_next;
    end

endmodule

/* tb/totp_code_generator_top_tb.sv */
// Self-checking testbench for the one-time password generator: default, directed, random and backpressure tests.
`timescale 1ns / 1ps

module totp_code_generator_top_tb;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [totp_pkg::TS_W-1:0]       s_timestamp;
    logic                            m_valid;
    logic                            m_ready;
    logic [totp_pkg::CODE_W-1:0]     m_code;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [4:0]                      paddr;
    logic [63:0]                     pwdata;
    logic [63:0]                     prdata;
    logic                            pready;

    totp_code_generator_top uut (.*);

    logic [63:0] key_hi, key_lo;
    logic [15:0] step_cfg;
    logic [29:0] mod_cfg;

    logic [totp_pkg::CODE_W-1:0] code_queue[$];
    int  mismatches;
    int  idle_cycles;
    int  rx_wait;
    int  rx_draw;
    bit  timed_out;
    bit  hold_off;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] compress(logic [159:0] h, logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            tmp = rotl(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function automatic logic [totp_pkg::CODE_W-1:0] totp_code(logic [totp_pkg::TS_W-1:0] ts);
        logic [511:0] ipad, opad;
        logic [159:0] h, inner;
        logic [63:0]  ctr;
        logic [7:0]   dig[20];
        logic [31:0]  tr;
        int off;
        ipad = {{key_hi, key_lo} ^ {16{8'h36}}, {48{8'h36}}};
        opad = {{key_hi, key_lo} ^ {16{8'h5C}}, {48{8'h5C}}};
        ctr = {1'b0, ts} / ((step_cfg == 0) ? 64'd1 : {48'd0, step_cfg});
        h = compress(totp_pkg::SHA1_IV, ipad);
        inner = compress(h, {ctr, 32'h80000000, 384'd0, 32'd576});
        h = compress(totp_pkg::SHA1_IV, opad);
        h = compress(h, {inner, 32'h80000000, 288'd0, 32'd672});
        for (int i = 0; i < 20; i++) dig[i] = h[159 - 8 * i -: 8];
        off = dig[19] & 8'h0F;
        tr = {1'b0, dig[off][6:0], dig[off+1], dig[off+2], dig[off+3]};
        if (mod_cfg != 0) tr = tr % {2'b0, mod_cfg};
        return tr[29:0];
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        paddr <= {idx, 3'b000}; pwdata <= val; pwrite <= 1'b1; psel <= 1'b1; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            totp_pkg::REG_KEY_UPPER: key_hi = val;
            totp_pkg::REG_KEY_LOWER: key_lo = val;
            totp_pkg::REG_TIME_STEP: step_cfg = val[15:0];
            totp_pkg::REG_CODE_MOD:  mod_cfg = val[29:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [63:0] hi, logic [63:0] lo, logic [15:0] st, logic [29:0] md);
        write_reg(totp_pkg::REG_KEY_UPPER, hi);
        write_reg(totp_pkg::REG_KEY_LOWER, lo);
        write_reg(totp_pkg::REG_TIME_STEP, {48'd0, st});
        write_reg(totp_pkg::REG_CODE_MOD, {34'd0, md});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_timestamp(logic [totp_pkg::TS_W-1:0] ts, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 7) : 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            wait_cycles(n);
        end
        s_valid <= 1'b1;
        s_timestamp <= ts;
        code_queue.push_back(totp_code(ts));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (code_queue.size() != 0 && !timed_out) @(posedge aclk);
        wait_cycles(20);
    endtask

    function automatic logic [totp_pkg::TS_W-1:0] rand_ts();
        logic [totp_pkg::TS_W-1:0] v;
        v = totp_pkg::TS_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = v & 63'hFFFF_FFFF;
            1: v = v >> $urandom_range(0, 62);
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            rx_draw = $urandom_range(0, 7);
            m_ready <= (rx_draw == 0);
            rx_wait <= (rx_draw == 0) ? 0 : rx_draw - 1;
        end else if (!m_ready) begin
            if (rx_wait == 0) begin
                m_ready <= 1'b1;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (code_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: code %0d", m_code);
            end else begin
                if (m_code !== code_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Code mismatch: expected %0d, actual %0d",
                                 code_queue[0], m_code);
                end
                void'(code_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                timed_out = 1'b1;
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic test_defaults();
        send_timestamp(63'd0, 0);
        send_timestamp(63'd59, 0);
        send_timestamp(63'h7FFF_FFFF_FFFF_FFFF, 0);
        drain();
    endtask

    task automatic test_directed();
        configure("12345678", "90123456", 16'd30, 30'd100000000);
        send_timestamp(63'd59, 0);
        send_timestamp(63'd1111111109, 0);
        send_timestamp(63'd20000000000, 0);
        drain();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 30'd0);
        send_timestamp(63'd0, 0);
        send_timestamp(63'h7FFF_FFFF_FFFF_FFFF, 0);
        send_timestamp(63'h2AAA_AAAA_AAAA_AAAA, 0);
        drain();
        configure(64'd0, 64'd1, 16'hFFFF, 30'h3FFF_FFFF);
        send_timestamp(63'h7FFF_FFFF_FFFF_FFFF, 0);
        send_timestamp(63'h5555_5555_5555_5555, 0);
        send_timestamp(63'd65534, 0);
        drain();
        configure(64'h8000_0000_0000_0000, 64'd0, 16'd1, 30'd1);
        send_timestamp(63'd12345, 0);
        send_timestamp(63'd1, 0);
        drain();
        configure(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'd1, 30'd1000000000);
        send_timestamp(63'h7FFF_FFFF_FFFF_FFFF, 0);
        send_timestamp(63'd999, 0);
        drain();
    endtask

    task automatic test_random();
        logic [15:0] st;
        logic [29:0] md;
        for (int p = 0; p < 22 && !timed_out; p++) begin
            case ($urandom_range(0, 3))
                0: st = 16'($urandom_range(0, 1));
                1: st = 16'hFFFF;
                default: st = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: md = 30'($urandom_range(0, 2));
                1: md = 30'h3FFF_FFFF;
                2: md = 30'd1000000;
                default: md = 30'($urandom);
            endcase
            configure({$urandom, $urandom}, {$urandom, $urandom}, st, md);
            for (int i = 0; i < 80; i++) send_timestamp(rand_ts(), $urandom_range(0, 3) != 0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                wait_cycles(3000);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_timestamp(rand_ts(), 0);
        join
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_timestamp = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_ready = 1'b0;
        key_hi = '0; key_lo = '0; step_cfg = 16'd30; mod_cfg = 30'd1000000;
        mismatches = 0; timed_out = 1'b0; hold_off = 1'b0;
        wait_cycles(2);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_directed();
        test_backpressure();
        test_random();
        drain();
        wait_cycles(800);
        if (mismatches == 0 && code_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/totp_pkg.sv
hw/rtl/totp_front.sv
hw/rtl/totp_fifo.sv
hw/rtl/totp_back.sv
hw/rtl/totp_code_generator_top.sv
tb/totp_code_generator_top_tb.sv
